@@ hdl/acia_pkg.sv @@
// Shared types, constants and the interrupt recompute for the ACIA register block.
package acia_pkg;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // Register addresses
    localparam logic ADDR_CTRL = 1'b0;
    localparam logic ADDR_DATA = 1'b1;

    // Status bits
    localparam logic [7:0] ST_RXFULL  = 8'h01;
    localparam logic [7:0] ST_TXEMPTY = 8'h02;
    localparam logic [7:0] ST_OVERRUN = 8'h20;
    localparam logic [7:0] ST_IRQ     = 8'h80;
    localparam logic [7:0] ST_IRQMASK = 8'h7F;

    // Control bits
    localparam logic [7:0] CT_IRQEN   = 8'h80;
    localparam logic [7:0] CT_TXMASK  = 8'h60;
    localparam logic [7:0] CT_TXIRQ   = 8'h20;
    localparam logic [7:0] CT_DIVMASK = 8'h03;

    // Stream widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // One input item
    typedef struct packed {
        t_op        operation;
        logic       address;
        logic [7:0] write_data;
        logic       rx_available;
        logic [7:0] rx_byte;
        logic       tx_clear;
    } t_item;

    // One result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
    } t_result;

    // Outcome of an interrupt recompute
    typedef struct packed {
        logic [7:0] status;
        logic       irq;
    } t_irq_upd;

    // Recompute the status interrupt bit and the interrupt level
    function automatic t_irq_upd irq_update(input logic [7:0] status,
                                            input logic [7:0] control);
        t_irq_upd   res;
        logic [7:0] s;
        s = status & ST_IRQMASK;
        if (((s & ST_RXFULL) != 8'h00) && ((control & CT_IRQEN) != 8'h00))
            s = s | ST_IRQ;
        if (((s & ST_TXEMPTY) != 8'h00) && ((control & CT_TXMASK) == CT_TXIRQ))
            s = s | ST_IRQ;
        if (((control & CT_IRQEN) == 8'h00) || ((s & ST_IRQ) == 8'h00)) begin
            res.status = s & ST_IRQMASK;
            res.irq    = 1'b0;
        end else begin
            res.status = s;
            res.irq    = 1'b1;
        end
        return res;
    endfunction

endpackage

@@ hdl/acia_core.sv @@
// Register state of the ACIA and the single-pass update for one beat.
module acia_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_rx_enable,
    input  acia_pkg::t_item  i_item,
    output acia_pkg::t_result o_result
);
    import acia_pkg::*;

    logic [7:0] r_status, n_status;
    logic [7:0] r_control, n_control;
    logic [7:0] r_rx_byte, n_rx_byte;
    logic       r_in_reset, n_in_reset;
    logic       r_irq, n_irq;
    t_irq_upd   upd;

    // Next state and result for the item in the input register
    always_comb begin
        n_status   = r_status;
        n_control  = r_control;
        n_rx_byte  = r_rx_byte;
        n_in_reset = r_in_reset;
        n_irq      = r_irq;
        upd        = '0;
        o_result   = '0;
        case (i_item.operation)
            OP_READ: begin
                if (i_item.address == ADDR_CTRL) begin
                    o_result.read_data = r_in_reset ? 8'h00 : r_status;
                end else begin
                    upd       = irq_update(r_status & ~(ST_RXFULL | ST_OVERRUN), r_control);
                    n_status  = upd.status;
                    n_irq     = upd.irq;
                    o_result.read_data = r_rx_byte;
                end
            end
            OP_WRITE: begin
                if (i_item.address == ADDR_CTRL) begin
                    n_control = i_item.write_data;
                    if ((i_item.write_data & CT_DIVMASK) == CT_DIVMASK) begin
                        n_in_reset = 1'b1;
                    end else if (r_in_reset) begin
                        n_in_reset = 1'b0;
                        n_status   = ST_TXEMPTY;
                    end
                    upd      = irq_update(n_status, n_control);
                    n_status = upd.status;
                    n_irq    = upd.irq;
                end else begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_byte  = i_item.write_data;
                    upd      = irq_update(r_status & ~ST_TXEMPTY, r_control);
                    n_status = upd.status;
                    n_irq    = upd.irq;
                end
            end
            OP_TICK: begin
                // accept an offered byte when receive is enabled and not in reset, flag overrun if one was waiting
                if (i_item.rx_available && i_rx_enable && !r_in_reset) begin
                    if ((r_status & ST_RXFULL) != 8'h00)
                        n_status = n_status | ST_OVERRUN;
                    n_rx_byte = i_item.rx_byte;
                    n_status  = n_status | ST_RXFULL;
                end
                if (i_item.tx_clear)
                    n_status = n_status | ST_TXEMPTY;
                if (i_item.rx_available || i_item.tx_clear) begin
                    upd      = irq_update(n_status, r_control);
                    n_status = upd.status;
                    n_irq    = upd.irq;
                end
            end
            default: begin
                // unused code: no change
            end
        endcase
        o_result.irq = n_irq;
    end

    // State registers, updated as a beat moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= ST_TXEMPTY;
            r_control  <= 8'h00;
            r_rx_byte  <= 8'h00;
            r_in_reset <= 1'b0;
            r_irq      <= 1'b0;
        end else if (i_advance) begin
            r_status   <= n_status;
            r_control  <= n_control;
            r_rx_byte  <= n_rx_byte;
            r_in_reset <= n_in_reset;
            r_irq      <= n_irq;
        end
    end

endmodule

@@ hdl/serial_acia_registers.sv @@
// Top level of the ACIA register block: stream ports, input and result registers.
//
// A simplified 6850-style serial interface driven by a stream of beats, each a register
// read, a register write or a serial-side tick, and answering each with exactly one
// result beat (read data, transmit byte and interrupt level). A beat passes through an
// input register, one pass of update logic that also writes the device registers, and a
// result register; a new beat is taken every clock cycle, so the sustained rate is one
// beat per cycle, stalling only while the result register is full and not taken. The
// receive enable is set through the configuration port and should be written only while
// no beat is in flight.
module serial_acia_registers (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: receive enable
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] address, [8:1] write_data, [9] rx_available, [17:10] rx_byte,
    // [18] tx_clear, [23:19] zero
    input  logic [acia_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] operation
    input  logic [acia_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] irq, [23:18] zero
    output logic [acia_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import acia_pkg::*;

    logic    r_rx_enable;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;
    logic    accept;

    // Pipeline handshake
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_rx_enable <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.operation    <= t_op'(i_s_axis_tuser[1:0]);
            r_in.address      <= i_s_axis_tdata[0];
            r_in.write_data   <= i_s_axis_tdata[8:1];
            r_in.rx_available <= i_s_axis_tdata[9];
            r_in.rx_byte      <= i_s_axis_tdata[17:10];
            r_in.tx_clear     <= i_s_axis_tdata[18];
        end
    end

    acia_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_rx_enable (r_rx_enable),
        .i_item      (r_in),
        .o_result    (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.irq, r_out.tx_byte, r_out.tx_valid, r_out.read_data};

endmodule
